>>> src/slow_pwm_valve_min_on_time_core_assert.svh
`ifndef SLOW_PWM_VALVE_MIN_ON_TIME_CORE_ASSERT_SVH
`define SLOW_PWM_VALVE_MIN_ON_TIME_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spv check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SPV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spv check failed");

`endif

>>> src/spv_pkg.sv
package spv_pkg;

  localparam int NOW_W          = 32;
  localparam int PCT_W          = 7;
  localparam int PER_W          = 16;
  localparam int PROD_W         = PCT_W + PER_W;
  localparam int CNT_W          = $clog2(PROD_W + 1);
  localparam int TIME_WIDTH_DEF = 32;

  // Rounded-up 2^30 / 100, exact for every dividend below 2^23.
  localparam int RECIP_W   = 24;
  localparam int REQ_SHIFT = 30;
  localparam logic [RECIP_W-1:0] REQ_RECIP = RECIP_W'(10737419);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  localparam logic [PCT_W-1:0] DUTY_RST   = '0;
  localparam logic [PER_W-1:0] BASE_RST   = PER_W'(1000);
  localparam logic [PER_W-1:0] MIN_ON_RST = PER_W'(100);

  localparam logic [1:0] REG_DUTY   = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_MIN_ON = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REQ,
    S_CHECK,
    S_PER_WAIT,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [PCT_W-1:0] duty;
    logic [PER_W-1:0] base;
    logic [PER_W-1:0] min_on;
  } cfg_t;

  typedef struct packed {
    logic load_now;
    logic mul;
    logic div_start;
    logic take_req;
    logic take_per;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic need_stretch;
    logic out_free;
  } sts_t;

endpackage

>>> src/slow_pwm_valve_min_on_time_core.sv
// Slow time-proportioning PWM for a valve with a minimum open time. Each item is a
// free-running millisecond time stamp and yields one item holding the valve drive bit.
// The on time is duty * base period / 100 (duty saturates at 100); a nonzero request
// below min_on_ms opens the valve for min_on_ms and stretches the period to
// min_on_ms * 100 / duty. The division by 100 is a multiply by a reciprocal, and the
// stretched period comes from a bit-serial divider, one quotient bit per cycle over
// 23 bits. One item is worked on at a time: a new one is taken only once the last
// has been committed, and a commit waits while an earlier result is stalled in the
// output register. The next item is accepted while a finished result still waits in
// the output register. Time wraps modulo 2^TIME_WIDTH; configuration is written
// through the APB port at byte addresses 0 (duty), 4 (base period) and 8 (minimum on
// time).
module slow_pwm_valve_min_on_time_core #(
  parameter int TIME_WIDTH = spv_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spv_pkg::ADDR_W-1:0]  paddr,
  input  logic [spv_pkg::DATA_W-1:0]  pwdata,
  output logic [spv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spv_pkg::NOW_W-1:0]   now_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        valve_on
);

  spv_pkg::cfg_t cfg;
  spv_pkg::cmd_t cmd;
  spv_pkg::sts_t sts;

  spv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spv_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valve_on  (valve_on)
  );

endmodule

>>> src/spv_regs.sv
module spv_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spv_pkg::ADDR_W-1:0]  paddr,
  input  logic [spv_pkg::DATA_W-1:0]  pwdata,
  output logic [spv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output spv_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty   <= spv_pkg::DUTY_RST;
      cfg.base   <= spv_pkg::BASE_RST;
      cfg.min_on <= spv_pkg::MIN_ON_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        spv_pkg::REG_DUTY:   cfg.duty   <= pwdata[spv_pkg::PCT_W-1:0];
        spv_pkg::REG_BASE:   cfg.base   <= pwdata[spv_pkg::PER_W-1:0];
        spv_pkg::REG_MIN_ON: cfg.min_on <= pwdata[spv_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      spv_pkg::REG_DUTY:   prdata = spv_pkg::DATA_W'(cfg.duty);
      spv_pkg::REG_BASE:   prdata = spv_pkg::DATA_W'(cfg.base);
      spv_pkg::REG_MIN_ON: prdata = spv_pkg::DATA_W'(cfg.min_on);
      default:             prdata = '0;
    endcase
  end

endmodule

>>> src/spv_div.sv
`include "slow_pwm_valve_min_on_time_core_assert.svh"

module spv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spv_pkg::PROD_W-1:0]  dividend,
  input  logic [spv_pkg::PCT_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [spv_pkg::PROD_W-1:0]  quotient
);

  logic [spv_pkg::PROD_W-1:0] dq;
  logic [spv_pkg::PCT_W-1:0]  rem;
  logic [spv_pkg::PCT_W-1:0]  dvs;
  logic [spv_pkg::CNT_W-1:0]  cnt;
  logic [spv_pkg::PCT_W:0]    rem_shift;
  logic [spv_pkg::PCT_W:0]    rem_diff;
  logic                       ge;

  // One restoring step per cycle; quotient bits shift in where dividend bits leave.
  assign rem_shift = {rem, dq[spv_pkg::PROD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign ge        = rem_shift >= {1'b0, dvs};
  assign quotient  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= spv_pkg::CNT_W'(spv_pkg::PROD_W);
      end else if (busy) begin
        cnt <= cnt - spv_pkg::CNT_W'(1);
        if (cnt == spv_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[spv_pkg::PROD_W-2:0], ge};
      rem <= ge ? rem_diff[spv_pkg::PCT_W-1:0] : rem_shift[spv_pkg::PCT_W-1:0];
    end
  end

  `SPV_ASSERT_NEXT(a_div_finish, clk, rst, busy && !start && cnt == spv_pkg::CNT_W'(1), done && !busy)

endmodule

>>> src/spv_dp.sv
module spv_dp #(
  parameter int TIME_WIDTH = spv_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spv_pkg::cfg_t              cfg,
  input  spv_pkg::cmd_t              cmd,
  output spv_pkg::sts_t              sts,
  input  logic [spv_pkg::NOW_W-1:0]  now_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       valve_on
);

  localparam int CMP_W = (TIME_WIDTH > spv_pkg::PROD_W) ? TIME_WIDTH : spv_pkg::PROD_W;
  localparam int SCL_W = spv_pkg::PROD_W + spv_pkg::RECIP_W;

  logic [TIME_WIDTH-1:0]      now_t;
  logic [TIME_WIDTH-1:0]      cycle_start;
  logic [TIME_WIDTH-1:0]      cycle_start_next;
  logic [TIME_WIDTH-1:0]      elapsed;
  logic                       valve_open;
  logic                       valve_open_next;
  logic [spv_pkg::PROD_W-1:0] prod_req;
  logic [spv_pkg::PROD_W-1:0] prod_min;
  logic [SCL_W-1:0]           req_scaled;
  logic [spv_pkg::PER_W-1:0]  req;
  logic [spv_pkg::PROD_W-1:0] period;
  logic [spv_pkg::PER_W-1:0]  on_time;
  logic [spv_pkg::PCT_W-1:0]  pct;
  logic                       stretch;
  logic [CMP_W-1:0]           el_x;
  logic [CMP_W-1:0]           on_x;
  logic [CMP_W-1:0]           per_x;
  logic [spv_pkg::PROD_W-1:0] div_quo;
  logic                       div_busy;
  logic                       div_done;

  assign pct = (cfg.duty > spv_pkg::PCT_FULL) ? spv_pkg::PCT_FULL : cfg.duty;

  // The request divides by 100 through a multiply by the reciprocal.
  assign req_scaled = SCL_W'(prod_req) * SCL_W'(spv_pkg::REQ_RECIP);

  spv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_min),
    .divisor  (pct),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // A nonzero request below the minimum open time gets the minimum and a stretched period.
  assign stretch = (req != '0) && (req < cfg.min_on);
  assign on_time = (req == '0) ? '0 : (stretch ? cfg.min_on : req);

  assign elapsed = now_t - cycle_start;
  assign el_x    = CMP_W'(elapsed);
  assign on_x    = CMP_W'(on_time);
  assign per_x   = CMP_W'(period);

  always_comb begin
    valve_open_next  = valve_open;
    cycle_start_next = cycle_start;
    if (valve_open) begin
      if ((el_x > on_x) && (spv_pkg::PROD_W'(on_time) < period)) begin
        valve_open_next = 1'b0;
      end
    end else if ((el_x > per_x) && (on_time != '0)) begin
      valve_open_next  = 1'b1;
      cycle_start_next = cycle_start + TIME_WIDTH'(period);
    end
  end

  assign sts.div_busy     = div_busy;
  assign sts.div_done     = div_done;
  assign sts.need_stretch = stretch;
  assign sts.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      now_t <= TIME_WIDTH'(now_ms);
    end
    if (cmd.mul) begin
      prod_req <= spv_pkg::PROD_W'(pct) * spv_pkg::PROD_W'(cfg.base);
      prod_min <= spv_pkg::PROD_W'(cfg.min_on) * spv_pkg::PROD_W'(spv_pkg::PCT_FULL);
    end
    if (cmd.take_req) begin
      req    <= req_scaled[spv_pkg::REQ_SHIFT +: spv_pkg::PER_W];
      period <= spv_pkg::PROD_W'(cfg.base);
    end else if (cmd.take_per) begin
      period <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valve_open  <= 1'b0;
      cycle_start <= '0;
      out_valid   <= 1'b0;
      valve_on    <= 1'b0;
    end else if (cmd.commit) begin
      valve_open  <= valve_open_next;
      cycle_start <= cycle_start_next;
      out_valid   <= 1'b1;
      valve_on    <= valve_open_next;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/spv_ctrl.sv
`include "slow_pwm_valve_min_on_time_core_assert.svh"

module spv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  spv_pkg::sts_t  sts,
  output spv_pkg::cmd_t  cmd
);

  spv_pkg::state_t state;
  spv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      spv_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_now = 1'b1;
          state_next   = spv_pkg::S_MUL;
        end
      end
      spv_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = spv_pkg::S_REQ;
      end
      spv_pkg::S_REQ: begin
        cmd.take_req = 1'b1;
        state_next   = spv_pkg::S_CHECK;
      end
      spv_pkg::S_CHECK: begin
        if (sts.need_stretch) begin
          cmd.div_start = 1'b1;
          state_next    = spv_pkg::S_PER_WAIT;
        end else begin
          state_next = spv_pkg::S_DECIDE;
        end
      end
      spv_pkg::S_PER_WAIT: begin
        if (sts.div_done) begin
          cmd.take_per = 1'b1;
          state_next   = spv_pkg::S_DECIDE;
        end
      end
      spv_pkg::S_DECIDE: begin
        // The valve state and the result move together, so wait for a free output.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = spv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spv_pkg::S_IDLE;
      end
    endcase
  end

  `SPV_ASSERT_NOW(a_start_idle_div, clk, rst, cmd.div_start, !sts.div_busy)
  `SPV_ASSERT_NOW(a_commit_free, clk, rst, cmd.commit, sts.out_free)
  `SPV_ASSERT_NEXT(a_accept_mul, clk, rst, state == spv_pkg::S_IDLE && in_valid, state == spv_pkg::S_MUL)

endmodule
